@@ hdl/btas_pkg.sv @@
// Shared types, constants and the arctangent table for the bearing, turn and speed core.
package btas_pkg;

    // Default values of the top-level parameters.
    localparam int COORD_BITS_DEF   = 12;
    localparam int CORDIC_STEPS_DEF = 16;

    // Fixed widths of the transaction fields.
    localparam int COORD_W = 12;
    localparam int HEAD_W  = 9;
    localparam int TURN_W  = 8;
    localparam int BEAR_W  = 9;
    localparam int DIST_W  = 13;
    localparam int SPEED_W = 8;
    localparam int TOL_W   = 6;
    localparam int ANGLE_W = 7;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_TOL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_DIST  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_DIST  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_SPEED = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_SPEED = 3'd4;

    // CORDIC fixed-point format: vectors carry 20 fraction bits, angles 16.
    localparam int GUARD_BITS = 20;
    localparam int ANG_FRAC   = 16;
    localparam int ANG_ONE    = 65536;
    localparam int ATAN_W     = 22;
    localparam int ATAN_LEN   = 24;
    localparam int ATAN_IDX_W = 5;

    typedef struct packed {
        logic [COORD_W-1:0] robot_x;
        logic [COORD_W-1:0] robot_y;
        logic [COORD_W-1:0] target_x;
        logic [COORD_W-1:0] target_y;
        logic [HEAD_W-1:0]  heading;
    } item_t;

    typedef struct packed {
        logic [TURN_W-1:0]  turn_angle;
        logic               turn_right;
        logic [BEAR_W-1:0]  bearing;
        logic [DIST_W-1:0]  distance;
        logic [SPEED_W-1:0] speed_code;
    } result_t;

    // Steering decision handed from the turn logic to the top level.
    typedef struct packed {
        logic [TURN_W-1:0] turn_angle;
        logic              turn_right;
        logic [BEAR_W-1:0] bearing;
    } turn_info_t;

    // atan(2^-i) in degrees, scaled by 2^16 and rounded.
    function automatic logic [ATAN_W-1:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
        logic [ATAN_W-1:0] val;
        begin
            case (idx)
                5'd0:    val = 22'd2949120;
                5'd1:    val = 22'd1740967;
                5'd2:    val = 22'd919879;
                5'd3:    val = 22'd466945;
                5'd4:    val = 22'd234379;
                5'd5:    val = 22'd117304;
                5'd6:    val = 22'd58666;
                5'd7:    val = 22'd29335;
                5'd8:    val = 22'd14668;
                5'd9:    val = 22'd7334;
                5'd10:   val = 22'd3667;
                5'd11:   val = 22'd1833;
                5'd12:   val = 22'd917;
                5'd13:   val = 22'd458;
                5'd14:   val = 22'd229;
                5'd15:   val = 22'd115;
                5'd16:   val = 22'd57;
                5'd17:   val = 22'd29;
                5'd18:   val = 22'd14;
                5'd19:   val = 22'd7;
                5'd20:   val = 22'd4;
                5'd21:   val = 22'd2;
                5'd22:   val = 22'd1;
                default: val = 22'd0;
            endcase
            return val;
        end
    endfunction

endpackage

@@ hdl/bearing_turn_and_speed_core.sv @@
// Top level of the bearing, turn and speed core: sequencer, configuration and result register.
//
//  Channel  | Handshake                 | Payload
//  ---------+---------------------------+-------------------------------------------
//  item     | item_valid / item_ready   | item: robot and target x/y, heading
//  result   | result_valid / result_ready | result: turn, direction, bearing, distance, speed
//  cfg      | cfg_valid / cfg_ready     | cfg_index, cfg_data (write only)
//
// One transaction is accepted while the sequencer is idle. The deltas are squared in
// the SQ state, both iterative units are loaded in the LOAD state, and then CORDIC_STEPS
// vectoring steps and COORD_BITS+1 root steps run side by side, one step per cycle.
// The result is registered in the finish step once both loops are done, and the
// sequencer then returns to idle to take a new item, so the longer of
// the two iterative loops sets the rate. A result that is not taken stalls only the
// finish step; the next item is accepted while the result register is still full.
// Reset restores the configuration defaults and sets the held direction to left.
module bearing_turn_and_speed_core
    import btas_pkg::*;
#(
    parameter int COORD_BITS   = COORD_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  item_t                 item,
    output logic                  result_valid,
    input  logic                  result_ready,
    output result_t               result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int NW    = 2 * COORD_BITS + 1;
    localparam int RW    = COORD_BITS + 1;
    localparam int CMP_W = (RW > DIST_W) ? RW : DIST_W;

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SQ   = 3'd1;
    localparam logic [2:0] S_LOAD = 3'd2;
    localparam logic [2:0] S_RUN  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    // Configuration defaults after reset.
    localparam logic [TOL_W-1:0]   TOL_RST        = 6'd4;
    localparam logic [DIST_W-1:0]  STOP_RST       = 13'd40;
    localparam logic [DIST_W-1:0]  FAST_RST       = 13'd140;
    localparam logic [SPEED_W-1:0] SLOW_SPEED_RST = 8'd1;
    localparam logic [SPEED_W-1:0] FAST_SPEED_RST = 8'd2;

    logic [2:0]              state_reg, state_next;
    logic [COORD_BITS-1:0]   dx_reg, dx_next, dy_reg, dy_next;
    logic                    rx_lt_reg, rx_lt_next, ry_lt_reg, ry_lt_next;
    logic [HEAD_W-1:0]       head_reg, head_next;
    logic [2*COORD_BITS-1:0] sqa_reg, sqa_next, sqb_reg, sqb_next;
    logic                    held_dir_reg, held_dir_next;
    result_t                 result_reg, result_next;
    logic                    result_valid_reg, result_valid_next;

    logic [TOL_W-1:0]   tol_reg, tol_next;
    logic [DIST_W-1:0]  stop_reg, stop_next, fast_reg, fast_next;
    logic [SPEED_W-1:0] slow_spd_reg, slow_spd_next, fast_spd_reg, fast_spd_next;

    logic [COORD_BITS-1:0] rx, ry, tx, ty;
    logic                  units_start;
    logic                  cordic_done, sqrt_done;
    logic [ANGLE_W-1:0]    angle;
    logic [NW-1:0]         sum_sq;
    logic [RW-1:0]         root;
    logic [CMP_W-1:0]      dist_cmp;
    logic [SPEED_W-1:0]    speed;
    logic                  finish;
    turn_info_t            turn_info;

    btas_cordic #(
        .COORD_BITS   (COORD_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (units_start),
        .dx    (dx_reg),
        .dy    (dy_reg),
        .done  (cordic_done),
        .angle (angle)
    );

    btas_isqrt #(
        .COORD_BITS (COORD_BITS)
    ) u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (units_start),
        .n     (sum_sq),
        .done  (sqrt_done),
        .root  (root)
    );

    btas_turn u_turn (
        .angle     (angle),
        .rx_lt_tx  (rx_lt_reg),
        .ry_lt_ty  (ry_lt_reg),
        .heading   (head_reg),
        .tolerance (tol_reg),
        .held_dir  (held_dir_reg),
        .info      (turn_info)
    );

    // Only the low COORD_BITS bits of each coordinate take part.
    assign rx = COORD_BITS'(item.robot_x);
    assign ry = COORD_BITS'(item.robot_y);
    assign tx = COORD_BITS'(item.target_x);
    assign ty = COORD_BITS'(item.target_y);

    assign item_ready   = (state_reg == S_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign units_start = (state_reg == S_LOAD);
    assign sum_sq      = NW'(sqa_reg) + NW'(sqb_reg);

    // The finish step waits only while an older result is still unclaimed.
    assign finish = (state_reg == S_FIN) && !(result_valid_reg && !result_ready);

    // Speed band; the stop test wins when the bands cross.
    always_comb
    begin
        dist_cmp = CMP_W'(root);
        if (dist_cmp <= CMP_W'(stop_reg))
        begin
            speed = '0;
        end
        else if (dist_cmp >= CMP_W'(fast_reg))
        begin
            speed = fast_spd_reg;
        end
        else
        begin
            speed = slow_spd_reg;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        dx_next           = dx_reg;
        dy_next           = dy_reg;
        rx_lt_next        = rx_lt_reg;
        ry_lt_next        = ry_lt_reg;
        head_next         = head_reg;
        sqa_next          = sqa_reg;
        sqb_next          = sqb_reg;
        held_dir_next     = held_dir_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg;

        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    dx_next    = (rx > tx) ? rx - tx : tx - rx;
                    dy_next    = (ry > ty) ? ry - ty : ty - ry;
                    rx_lt_next = (rx < tx);
                    ry_lt_next = (ry < ty);
                    head_next  = item.heading;
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                sqa_next   = dx_reg * dx_reg;
                sqb_next   = dy_reg * dy_reg;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                state_next = S_RUN;
            end
            S_RUN:
            begin
                if (cordic_done && sqrt_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (finish)
                begin
                    result_next.turn_angle = turn_info.turn_angle;
                    result_next.turn_right = turn_info.turn_right;
                    result_next.bearing    = turn_info.bearing;
                    result_next.distance   = root[DIST_W-1:0];
                    result_next.speed_code = speed;
                    result_valid_next      = 1'b1;
                    held_dir_next          = turn_info.turn_right;
                    state_next             = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Register writes are masked to each register's width.
    always_comb
    begin
        tol_next      = tol_reg;
        stop_next     = stop_reg;
        fast_next     = fast_reg;
        slow_spd_next = slow_spd_reg;
        fast_spd_next = fast_spd_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ANGLE_TOL:              tol_next      = cfg_data[TOL_W-1:0];
                CFG_STOP_DIST:              stop_next     = cfg_data[DIST_W-1:0];
                CFG_FAST_DIST:              fast_next     = cfg_data[DIST_W-1:0];
                CFG_IDX_W'(CFG_SLOW_SPEED): slow_spd_next = cfg_data[SPEED_W-1:0];
                CFG_IDX_W'(CFG_FAST_SPEED): fast_spd_next = cfg_data[SPEED_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            held_dir_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            tol_reg          <= TOL_RST;
            stop_reg         <= STOP_RST;
            fast_reg         <= FAST_RST;
            slow_spd_reg     <= SLOW_SPEED_RST;
            fast_spd_reg     <= FAST_SPEED_RST;
        end
        else
        begin
            state_reg        <= state_next;
            held_dir_reg     <= held_dir_next;
            result_valid_reg <= result_valid_next;
            tol_reg          <= tol_next;
            stop_reg         <= stop_next;
            fast_reg         <= fast_next;
            slow_spd_reg     <= slow_spd_next;
            fast_spd_reg     <= fast_spd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        rx_lt_reg  <= rx_lt_next;
        ry_lt_reg  <= ry_lt_next;
        head_reg   <= head_next;
        sqa_reg    <= sqa_next;
        sqb_reg    <= sqb_next;
        result_reg <= result_next;
    end

    // The held direction moves only when a result is produced.
    a_held_only_at_finish: assert property (@(posedge clk) disable iff (!rst_n)
        !finish |=> $stable(held_dir_reg))
        else $error("held direction changed outside the finish step");

    // Both iterative units have finished whenever the finish step is reached.
    a_units_done_at_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN) |-> (cordic_done && sqrt_done))
        else $error("finish step reached with an iterative unit still busy");

    // An aligned result keeps the previous direction.
    a_zero_turn_keeps_dir: assert property (@(posedge clk) disable iff (!rst_n)
        (finish && (turn_info.turn_angle == '0)) |=> (held_dir_reg == $past(held_dir_reg)))
        else $error("zero turn changed the held direction");

    // A delivered result stays within the turn and bearing ranges.
    a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> ((result_reg.turn_angle <= TURN_W'(180))
                              && (result_reg.bearing <= BEAR_W'(360))))
        else $error("result turn or bearing out of range");

endmodule

@@ hdl/btas_cordic.sv @@
// Iterative CORDIC vectoring unit that yields the first-quadrant angle in whole degrees.
module btas_cordic
    import btas_pkg::*;
#(
    parameter int COORD_BITS   = COORD_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [COORD_BITS-1:0] dx,
    input  logic [COORD_BITS-1:0] dy,
    output logic                  done,
    output logic [ANGLE_W-1:0]    angle
);

    localparam int VW = COORD_BITS + GUARD_BITS + 3;
    localparam int ZW = 25;
    localparam int CW = $clog2(CORDIC_STEPS + 1);
    localparam logic signed [ZW-1:0] Z_MAX  = ZW'(90 * ANG_ONE);
    localparam logic signed [ZW-1:0] Z_HALF = ZW'(ANG_ONE / 2);

    logic signed [VW-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [ZW-1:0] z_reg, z_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 dx_zero_reg, dx_zero_next, dy_zero_reg, dy_zero_next;

    logic signed [VW-1:0] xs, ys;
    logic signed [ZW-1:0] step_ang, z_clamp, z_round;

    always_comb
    begin
        xs       = x_reg >>> cnt_reg;
        ys       = y_reg >>> cnt_reg;
        step_ang = $signed(ZW'(atan_entry(ATAN_IDX_W'(cnt_reg))));

        x_next       = x_reg;
        y_next       = y_reg;
        z_next       = z_reg;
        cnt_next     = cnt_reg;
        busy_next    = busy_reg;
        dx_zero_next = dx_zero_reg;
        dy_zero_next = dy_zero_reg;

        if (start)
        begin
            x_next       = $signed(VW'({dx, {GUARD_BITS{1'b0}}}));
            y_next       = $signed(VW'({dy, {GUARD_BITS{1'b0}}}));
            z_next       = '0;
            cnt_next     = '0;
            busy_next    = 1'b1;
            dx_zero_next = (dx == '0);
            dy_zero_next = (dy == '0);
        end
        else if (busy_reg)
        begin
            // Rotate toward the x axis; the sign of y picks the direction.
            if (y_reg > 0)
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + step_ang;
            end
            else
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - step_ang;
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(CORDIC_STEPS - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg       <= x_next;
        y_reg       <= y_next;
        z_reg       <= z_next;
        dx_zero_reg <= dx_zero_next;
        dy_zero_reg <= dy_zero_next;
    end

    always_comb
    begin
        if (z_reg < 0)
        begin
            z_clamp = '0;
        end
        else if (z_reg > Z_MAX)
        begin
            z_clamp = Z_MAX;
        end
        else
        begin
            z_clamp = z_reg;
        end
        z_round = z_clamp + Z_HALF;

        if (dy_zero_reg)
        begin
            angle = '0;
        end
        else if (dx_zero_reg)
        begin
            angle = ANGLE_W'(90);
        end
        else
        begin
            angle = z_round[ANG_FRAC+ANGLE_W-1:ANG_FRAC];
        end
    end

    assign done = ~busy_reg;

endmodule

@@ hdl/btas_isqrt.sv @@
// Digit-by-digit integer square root, one result bit per cycle.
module btas_isqrt
    import btas_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [2*COORD_BITS:0]   n,
    output logic                    done,
    output logic [COORD_BITS:0]     root
);

    localparam int NW = 2 * COORD_BITS + 1;
    localparam int RW = COORD_BITS + 1;

    logic [NW-1:0] rem_reg, rem_next, root_reg, root_next, bit_reg, bit_next;
    logic [NW:0]   trial;

    always_comb
    begin
        trial     = {1'b0, root_reg} + {1'b0, bit_reg};
        rem_next  = rem_reg;
        root_next = root_reg;
        bit_next  = bit_reg;

        if (start)
        begin
            rem_next  = n;
            root_next = '0;
            bit_next  = NW'(1) << (2 * COORD_BITS);
        end
        else if (bit_reg != '0)
        begin
            if ({1'b0, rem_reg} >= trial)
            begin
                rem_next  = rem_reg - trial[NW-1:0];
                root_next = (root_reg >> 1) + bit_reg;
            end
            else
            begin
                root_next = root_reg >> 1;
            end
            bit_next = bit_reg >> 2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_reg <= '0;
        end
        else
        begin
            bit_reg <= bit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = (bit_reg == '0);
    assign root = root_reg[RW-1:0];

endmodule

@@ hdl/btas_turn.sv @@
// Bearing from quadrant rules and shortest-turn decision against the heading.
module btas_turn
    import btas_pkg::*;
(
    input  logic [ANGLE_W-1:0] angle,
    input  logic               rx_lt_tx,
    input  logic               ry_lt_ty,
    input  logic [HEAD_W-1:0]  heading,
    input  logic [TOL_W-1:0]   tolerance,
    input  logic               held_dir,
    output turn_info_t         info
);

    localparam logic [2:0] Q_NONE  = 3'd0;
    localparam logic [2:0] Q_ONE   = 3'd1;
    localparam logic [2:0] Q_TWO   = 3'd2;
    localparam logic [2:0] Q_THREE = 3'd3;
    localparam logic [2:0] Q_FOUR  = 3'd4;

    logic [BEAR_W-1:0]  bear;
    logic [2:0]         qa, qh;
    logic signed [10:0] d, dw, turn_s;
    logic [10:0]        mag, tol_ext;
    logic               aligned, dir;

    always_comb
    begin
        unique case ({rx_lt_tx, ry_lt_ty})
            2'b11:
            begin
                bear = BEAR_W'(angle);
                qa   = Q_ONE;
            end
            2'b10:
            begin
                bear = BEAR_W'(360) - BEAR_W'(angle);
                qa   = Q_FOUR;
            end
            2'b01:
            begin
                bear = BEAR_W'(180) - BEAR_W'(angle);
                qa   = Q_TWO;
            end
            default:
            begin
                bear = BEAR_W'(180) + BEAR_W'(angle);
                qa   = Q_THREE;
            end
        endcase

        if (heading <= HEAD_W'(90))
        begin
            qh = Q_ONE;
        end
        else if (heading <= HEAD_W'(180))
        begin
            qh = Q_TWO;
        end
        else if (heading <= HEAD_W'(269))
        begin
            qh = Q_THREE;
        end
        else if (heading <= HEAD_W'(360))
        begin
            qh = Q_FOUR;
        end
        else
        begin
            qh = Q_NONE;
        end

        d       = $signed({2'b00, heading}) - $signed({2'b00, bear});
        mag     = (d < 0) ? 11'(-d) : 11'(d);
        tol_ext = 11'(tolerance);
        aligned = (mag <= tol_ext) || (mag >= 11'(360) - tol_ext);
        dw      = (d < -11'sd180) ? d + 11'sd360 : d;

        // Same quadrant: sign alone decides. Otherwise a half turn goes right.
        if (qa == qh)
        begin
            turn_s = (dw < 0) ? -dw : dw;
            dir    = (dw >= 0);
        end
        else if (dw < 0)
        begin
            if (-dw < 11'sd180)
            begin
                turn_s = -dw;
                dir    = 1'b0;
            end
            else
            begin
                turn_s = dw + 11'sd360;
                dir    = 1'b1;
            end
        end
        else if (dw > 11'sd180)
        begin
            turn_s = 11'sd360 - dw;
            dir    = 1'b0;
        end
        else
        begin
            turn_s = dw;
            dir    = 1'b1;
        end

        info.bearing    = bear;
        info.turn_angle = aligned ? '0 : turn_s[TURN_W-1:0];
        info.turn_right = aligned ? held_dir : dir;
    end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the bearing, turn and speed core.
module tb_top;
    import btas_pkg::*;

    // Quadrant codes used by the steering prediction. A heading above 360 has none.
    localparam int QUAD_NONE = 0;
    localparam int QUAD_1    = 1;
    localparam int QUAD_2    = 2;
    localparam int QUAD_3    = 3;
    localparam int QUAD_4    = 4;

    // Turn direction encoding on the result.
    localparam logic DIR_LEFT  = 1'b0;
    localparam logic DIR_RIGHT = 1'b1;

    // Limit on consecutive cycles without any accepted transaction. A correct
    // core returns each result well within this limit after it takes an item, so
    // even a long sender gap plus a receiver stall stays far below it.
    localparam int STALL_LIMIT = 2000;
    localparam int COORD_MAX   = 4095;

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    item_valid   = 1'b0;
    logic    item_ready;
    item_t   item         = '0;
    logic    result_valid;
    logic    result_ready = 1'b0;
    result_t result;
    logic    cfg_valid    = 1'b0;
    logic    cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    bearing_turn_and_speed_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // Shadow copy of the configuration and of the held turn direction. These
    // follow the core: the registers change only when a write is accepted, and
    // the direction is recomputed for each accepted item, in acceptance order.
    int unsigned tol_deg    = 4;
    int unsigned stop_dist  = 40;
    int unsigned fast_dist  = 140;
    int unsigned slow_code  = 1;
    int unsigned fast_code  = 2;
    logic        held_right = DIR_LEFT;

    // Steering results predicted for accepted items, oldest first.
    result_t pending_steer[$];

    // When set, neither side inserts idle cycles.
    bit no_idle = 1'b0;

    int fixes_sent      = 0;
    int results_checked = 0;
    int mismatches      = 0;
    int settings_used   = 1;
    int idle_cycles     = 0;

    // ------------------------------------------------------------------
    // Steering prediction
    // ------------------------------------------------------------------

    // atan(2^-i) in degrees scaled by 2^16, rounded.
    function automatic longint arctan_q16(input int i);
        longint v;
        case (i)
            0:       v = 2949120;
            1:       v = 1740967;
            2:       v = 919879;
            3:       v = 466945;
            4:       v = 234379;
            5:       v = 117304;
            6:       v = 58666;
            7:       v = 29335;
            8:       v = 14668;
            9:       v = 7334;
            10:      v = 3667;
            11:      v = 1833;
            12:      v = 917;
            13:      v = 458;
            14:      v = 229;
            15:      v = 115;
            16:      v = 57;
            17:      v = 29;
            18:      v = 14;
            19:      v = 7;
            20:      v = 4;
            21:      v = 2;
            22:      v = 1;
            default: v = 0;
        endcase
        return v;
    endfunction

    // Angle of (dx, dy) in whole degrees, 0..90, by CORDIC vectoring. The
    // arithmetic right shift of a signed value rounds toward minus infinity,
    // which is exactly what the core's vector shifts do.
    function automatic int vector_angle(input int dx, input int dy);
        longint x, y, z, xs, ys;
        int     i;
        z = 0;
        if (dy == 0)
            return 0;
        if (dx == 0)
            return 90;
        x = longint'(dx) <<< GUARD_BITS;
        y = longint'(dy) <<< GUARD_BITS;
        for (i = 0; i < CORDIC_STEPS_DEF && i < ATAN_LEN; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + arctan_q16(i);
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - arctan_q16(i);
            end
        end
        if (z < 0)
            z = 0;
        if (z > 90 * longint'(ANG_ONE))
            z = 90 * longint'(ANG_ONE);
        return int'((z + ANG_ONE / 2) >>> ANG_FRAC);
    endfunction

    // Bearing from robot to target and the quadrant it was placed in.
    function automatic int target_bearing(input item_t it, output int quad);
        int rx, ry, tx, ty, a;
        rx = int'(it.robot_x);
        ry = int'(it.robot_y);
        tx = int'(it.target_x);
        ty = int'(it.target_y);
        a  = vector_angle(rx > tx ? rx - tx : tx - rx, ry > ty ? ry - ty : ty - ry);
        if (rx < tx)
        begin
            quad = (ry < ty) ? QUAD_1 : QUAD_4;
            return (ry < ty) ? a : 360 - a;
        end
        quad = (ry < ty) ? QUAD_2 : QUAD_3;
        return (ry < ty) ? 180 - a : 180 + a;
    endfunction

    // Integer square root, built one result bit at a time from the top.
    function automatic int unsigned floor_root(input longint unsigned n);
        longint unsigned r, trial;
        int              b;
        r = 0;
        for (b = 13; b >= 0; b--)
        begin
            trial = r | (longint'(1) << b);
            if (trial * trial <= n)
                r = trial;
        end
        return int'(r);
    endfunction

    // Full steering and speed result for one accepted item. Updates the held
    // direction whenever a non-zero turn is commanded.
    function automatic result_t steer_and_speed(input item_t it);
        int          bearing, quad_b, quad_h, head, d, mag, turn, dx, dy;
        int unsigned range_px, speed;
        result_t     r;
        bearing = target_bearing(it, quad_b);
        head    = int'(it.heading);
        if (head <= 90)
            quad_h = QUAD_1;
        else if (head <= 180)
            quad_h = QUAD_2;
        else if (head <= 269)
            quad_h = QUAD_3;
        else if (head <= 360)
            quad_h = QUAD_4;
        else
            quad_h = QUAD_NONE;

        turn = 0;
        d    = head - bearing;
        mag  = (d < 0) ? -d : d;
        // Within tolerance of zero or of a full circle the robot counts as aligned.
        if (!(mag <= int'(tol_deg) || mag >= 360 - int'(tol_deg)))
        begin
            if (d < -180)
                d = d + 360;
            if (quad_b == quad_h)
            begin
                turn       = (d < 0) ? -d : d;
                held_right = (d < 0) ? DIR_LEFT : DIR_RIGHT;
            end
            else if (d < 0)
            begin
                // An error of exactly 180 degrees across quadrants turns right.
                if (-d < 180)
                begin
                    turn       = -d;
                    held_right = DIR_LEFT;
                end
                else
                begin
                    turn       = d + 360;
                    held_right = DIR_RIGHT;
                end
            end
            else if (d > 180)
            begin
                turn       = 360 - d;
                held_right = DIR_LEFT;
            end
            else
            begin
                turn       = d;
                held_right = DIR_RIGHT;
            end
        end

        dx       = int'(it.robot_x) - int'(it.target_x);
        dy       = int'(it.robot_y) - int'(it.target_y);
        range_px = floor_root(longint'(dx) * dx + longint'(dy) * dy);
        // The stop band wins when the two thresholds are crossed.
        if (range_px <= stop_dist)
            speed = 0;
        else if (range_px >= fast_dist)
            speed = fast_code;
        else
            speed = slow_code;

        r.turn_angle = TURN_W'(turn);
        r.turn_right = held_right;
        r.bearing    = BEAR_W'(bearing);
        r.distance   = DIST_W'(range_px);
        r.speed_code = SPEED_W'(speed);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic item_t fix(input int rx, input int ry, input int tx, input int ty,
                                  input int head);
        item_t it;
        it.robot_x  = COORD_W'(rx);
        it.robot_y  = COORD_W'(ry);
        it.target_x = COORD_W'(tx);
        it.target_y = COORD_W'(ty);
        it.heading  = HEAD_W'(head);
        return it;
    endfunction

    // Same geometry, with the heading placed a given offset from the true bearing.
    function automatic item_t aimed(input int rx, input int ry, input int tx, input int ty,
                                    input int offset);
        item_t it;
        int    quad, h;
        it = fix(rx, ry, tx, ty, 0);
        h  = (target_bearing(it, quad) + offset) % 360;
        if (h < 0)
            h = h + 360;
        it.heading = HEAD_W'(h);
        return it;
    endfunction

    // A coordinate within span of c, kept on the grid.
    function automatic int near(input int c, input int span);
        int d;
        d = $urandom_range(0, span);
        if ($urandom_range(0, 1))
            d = -d;
        if (c + d < 0 || c + d > COORD_MAX)
            d = -d;
        return c + d;
    endfunction

    // Random position fix. Short separations exercise the distance bands and
    // the axis cases; 55 percent of the headings are aimed relative to the bearing so that the
    // tolerance edges, the half-turn and the wrap through zero are all reached.
    function automatic item_t random_fix();
        item_t it;
        int    rx, ry, tx, ty, span, pick;
        rx = $urandom_range(0, COORD_MAX);
        ry = $urandom_range(0, COORD_MAX);
        if ($urandom_range(0, 99) < 30)
        begin
            span = ($urandom_range(0, 3) == 0) ? 3 : 900;
            tx   = near(rx, span);
            ty   = near(ry, span);
        end
        else
        begin
            tx = $urandom_range(0, COORD_MAX);
            ty = $urandom_range(0, COORD_MAX);
        end
        pick = $urandom_range(0, 99);
        if (pick < 55)
        begin
            case ($urandom_range(0, 3))
                0:       it = aimed(rx, ry, tx, ty, int'($urandom_range(0, 100)) - 50);
                1:       it = aimed(rx, ry, tx, ty, 177 + int'($urandom_range(0, 6)));
                2:       it = aimed(rx, ry, tx, ty, int'($urandom_range(0, 359)));
                default: it = aimed(rx, ry, tx, ty,
                                    ($urandom_range(0, 1) ? 1 : -1) *
                                    (int'(tol_deg) + int'($urandom_range(0, 2)) - 1));
            endcase
        end
        else if (pick < 90)
            it = fix(rx, ry, tx, ty, $urandom_range(0, 360));
        else
            it = fix(rx, ry, tx, ty, $urandom_range(361, 511));
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------

    // Offer one position fix and hold it until the core takes it. Returns at
    // the edge of acceptance without lowering valid, so that a following
    // transaction can go out back to back.
    task automatic send_fix(input item_t it);
        if (!no_idle && $urandom_range(0, 99) < 60)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 24)) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (!item_ready);
        pending_steer.push_back(steer_and_speed(it));
        fixes_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_ANGLE_TOL:  tol_deg   = value & 32'h3F;
            CFG_STOP_DIST:  stop_dist = value & 32'h1FFF;
            CFG_FAST_DIST:  fast_dist = value & 32'h1FFF;
            CFG_SLOW_SPEED: slow_code = value & 32'hFF;
            CFG_FAST_SPEED: fast_code = value & 32'hFF;
            default:        ;
        endcase
    endtask

    // Stop offering items and wait until every outstanding result is back.
    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending_steer.size() != 0)
            @(posedge clk);
    endtask

    // Reprogram all five registers while the core is idle.
    task automatic apply_settings(input int unsigned tol, input int unsigned stop_d,
                                  input int unsigned fast_d, input int unsigned slow_s,
                                  input int unsigned fast_s);
        drain();
        write_reg(CFG_ANGLE_TOL, tol);
        write_reg(CFG_STOP_DIST, stop_d);
        write_reg(CFG_FAST_DIST, fast_d);
        write_reg(CFG_SLOW_SPEED, slow_s);
        write_reg(CFG_FAST_SPEED, fast_s);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic send_random(input int count);
        repeat (count) send_fix(random_fix());
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hand-picked cases at the reset configuration: tolerance 4, stop 40, fast 140.
    task automatic test_directed_defaults();
        // Coincident points give bearing 180; aligned, then a half-turn error.
        send_fix(fix(100, 100, 100, 100, 180));
        send_fix(fix(100, 100, 100, 100, 0));
        // Corner-to-corner in every quadrant, at the largest distance.
        send_fix(fix(0, 0, COORD_MAX, COORD_MAX, 45));
        send_fix(fix(COORD_MAX, COORD_MAX, 0, 0, 0));
        send_fix(fix(0, COORD_MAX, COORD_MAX, 0, 360));
        send_fix(fix(COORD_MAX, 0, 0, COORD_MAX, 90));
        // Targets straight along an axis, including headings above 360.
        send_fix(fix(500, 100, 500, 900, 90));
        send_fix(fix(500, 900, 500, 100, 511));
        send_fix(fix(100, 300, 900, 300, 361));
        send_fix(fix(900, 300, 100, 300, 270));
        send_fix(fix(100, 300, 900, 300, 0));
        // Distance band edges: 40, 41, 139 and 140.
        send_fix(aimed(0, 0, 24, 32, 20));
        send_fix(aimed(0, 0, 41, 0, -20));
        send_fix(aimed(1000, 1000, 1139, 1000, 0));
        send_fix(aimed(1000, 1000, 1000, 1140, 90));
        // Tolerance edges on either side of the bearing.
        send_fix(aimed(200, 300, 900, 1000, 4));
        send_fix(aimed(200, 300, 900, 1000, 5));
        send_fix(aimed(200, 300, 900, 1000, -4));
        send_fix(aimed(200, 300, 900, 1000, -5));
        // A bearing near zero against headings just short of a full circle.
        send_fix(fix(0, 0, 1000, 35, 358));
        send_fix(fix(0, 0, 1000, 35, 357));
        // Large errors of both signs, and an exact half turn in one quadrant pair.
        send_fix(aimed(3000, 200, 100, 2500, 170));
        send_fix(aimed(3000, 200, 100, 2500, -170));
        send_fix(aimed(3000, 200, 100, 2500, 180));
    endtask

    task automatic test_random_defaults();
        send_random(400);
    endtask

    // Zero tolerance and zero thresholds: every separated pair is fast.
    task automatic test_tight_bands();
        apply_settings(0, 0, 0, 0, 255);
        send_random(200);
    endtask

    // Tolerance 45 and both thresholds above the largest distance: every distance stops.
    task automatic test_wide_bands();
        apply_settings(45, 5793, 5793, 255, 0);
        send_random(150);
    endtask

    // Fast threshold below the stop threshold.
    task automatic test_crossed_bands();
        apply_settings(20, 600, 200, 7, 200);
        send_random(200);
    endtask

    // Neither side idles, so items and results follow at the core's own pace.
    task automatic test_back_to_back();
        apply_settings(10, 100, 400, 3, 9);
        no_idle = 1'b1;
        send_random(150);
        drain();
        no_idle = 1'b0;
    endtask

    task automatic test_random_settings();
        repeat (4)
        begin
            apply_settings($urandom_range(0, 45), $urandom_range(0, 800),
                           $urandom_range(0, 3000), $urandom_range(0, 255),
                           $urandom_range(0, 255));
            send_random(50);
        end
    endtask

    // ------------------------------------------------------------------
    // Result checking and receiver back-pressure
    // ------------------------------------------------------------------

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_steer.size() == 0)
            begin
                $display("%0t: unexpected result transaction, expected none, got %h",
                         $time, result);
                mismatches++;
            end
            else
            begin
                want = pending_steer.pop_front();
                compare_field("turn_angle", 16'(want.turn_angle), 16'(result.turn_angle));
                compare_field("turn_right", 16'(want.turn_right), 16'(result.turn_right));
                compare_field("bearing", 16'(want.bearing), 16'(result.bearing));
                compare_field("distance", 16'(want.distance), 16'(result.distance));
                compare_field("speed_code", 16'(want.speed_code), 16'(result.speed_code));
                results_checked++;
            end
        end
        result_ready <= no_idle || ($urandom_range(0, 99) >= 32);
    end

    // Watchdog: ends the run when no transaction of any kind completes for too long.
    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready) ||
            (cfg_valid && cfg_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                     $time, STALL_LIMIT, pending_steer.size());
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_defaults();
        test_random_defaults();
        test_tight_bands();
        test_wide_bands();
        test_crossed_bands();
        test_back_to_back();
        test_random_settings();

        drain();
        // Give a stray extra result time to show up before closing.
        repeat (40) @(posedge clk);

        $display("Sent %0d position fixes and checked %0d results over %0d register settings.",
                 fixes_sent, results_checked, settings_used);
        $display("Field mismatches and unexpected results: %0d", mismatches);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
